/* hw/rtl/sfd_pkg.sv */
`default_nettype none

package sfd_pkg;

    // Channel count of angle and pressure frames
    localparam int CHANNELS = 6;
    // Channel slots on the result port
    localparam int OUT_CH   = 6;
    // Lanes evaluated by the spike filter (covers both counts)
    localparam int LANES    = (CHANNELS > OUT_CH) ? CHANNELS : OUT_CH;
    // Payload store: channel frames or brake frames, whichever is longer
    localparam int PAYLOAD_BYTES = (2 * CHANNELS > 4) ? 2 * CHANNELS : 4;
    // Byte counter width and length compare width
    localparam int IDX_W = 4;
    localparam int LEN_W = IDX_W + 1;

    localparam logic [15:0] SPIKE_LIMIT_RESET = 16'd1000;

    // Header bytes
    localparam logic [7:0] HDR_SYNC0      = 8'hAE;
    localparam logic [7:0] HDR_SYNC1      = 8'hEA;
    localparam logic [7:0] TYPE_ANGLE_A   = 8'h01;
    localparam logic [7:0] TYPE_ANGLE_B   = 8'h10;
    localparam logic [7:0] TYPE_PRESS_A   = 8'h02;
    localparam logic [7:0] TYPE_PRESS_B   = 8'h20;
    localparam logic [7:0] TYPE_ESTOP_A   = 8'h03;
    localparam logic [7:0] TYPE_ESTOP_B   = 8'h30;
    localparam logic [7:0] TYPE_BRAKE_A   = 8'h04;
    localparam logic [7:0] TYPE_BRAKE_B   = 8'h40;

    typedef enum logic [1:0] {
        KIND_ANGLE    = 2'd0,
        KIND_PRESSURE = 2'd1,
        KIND_ESTOP    = 2'd2,
        KIND_BRAKE    = 2'd3
    } frame_kind_t;

    // Completed frame handed from the framer to the filter
    typedef struct packed {
        logic                           valid;
        frame_kind_t                    kind;
        logic [PAYLOAD_BYTES-1:0][7:0]  bytes;
    } frame_done_t;

    // One formatted result
    typedef struct packed {
        frame_kind_t                kind;
        logic [OUT_CH-1:0][15:0]    ch;
        logic [OUT_CH-1:0]          held;
        logic                       estop;
        logic [7:0]                 brake_a;
        logic [7:0]                 brake_b;
    } result_t;

endpackage

`default_nettype wire

/* hw/rtl/sfd_rx_if.sv */
`default_nettype none

interface sfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       buffer_end;

    modport source (output valid, output rx_byte, output buffer_end, input ready);
    modport sink   (input valid, input rx_byte, input buffer_end, output ready);
endinterface

`default_nettype wire

/* hw/rtl/sfd_frame_if.sv */
`default_nettype none

interface sfd_frame_if;
    logic               valid;
    logic               ready;
    logic [1:0]         frame_kind;
    logic signed [15:0] ch0;
    logic signed [15:0] ch1;
    logic signed [15:0] ch2;
    logic signed [15:0] ch3;
    logic signed [15:0] ch4;
    logic signed [15:0] ch5;
    logic [5:0]         held_mask;
    logic               emergency_stop;
    logic [7:0]         brake_limit_a;
    logic [7:0]         brake_limit_b;

    modport source (
        output valid, output frame_kind, output ch0, output ch1, output ch2,
        output ch3, output ch4, output ch5, output held_mask,
        output emergency_stop, output brake_limit_a, output brake_limit_b,
        input ready
    );
    modport sink (
        input valid, input frame_kind, input ch0, input ch1, input ch2,
        input ch3, input ch4, input ch5, input held_mask,
        input emergency_stop, input brake_limit_a, input brake_limit_b,
        output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/sfd_framer.sv */
`default_nettype none

module sfd_framer
    import sfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        buffer_end,
    output frame_done_t      done
);

    localparam logic [LEN_W-1:0] LEN_CHAN  = LEN_W'(2 * CHANNELS);
    localparam logic [LEN_W-1:0] LEN_ESTOP = LEN_W'(2);
    localparam logic [LEN_W-1:0] LEN_BRAKE = LEN_W'(4);

    logic [23:0]                    window_reg, window_next;
    logic                           in_frame_reg, in_frame_next;
    frame_kind_t                    kind_reg, kind_next;
    logic [IDX_W-1:0]               index_reg, index_next;
    logic [PAYLOAD_BYTES-1:0][7:0]  payload_reg;
    logic [PAYLOAD_BYTES-1:0][7:0]  view;

    logic                           hdr_hit;
    frame_kind_t                    hdr_kind;
    logic [LEN_W-1:0]               frame_len;
    logic [LEN_W-1:0]               index_inc;
    logic                           last_byte;

    // Header match on the last three window bytes plus the current beat
    always_comb
    begin
        hdr_hit  = 1'b0;
        hdr_kind = KIND_ANGLE;
        if (window_reg[23:16] == HDR_SYNC0 && window_reg[15:8] == HDR_SYNC1)
        begin
            if (window_reg[7:0] == TYPE_ANGLE_A && rx_byte == TYPE_ANGLE_B)
            begin
                hdr_hit  = 1'b1;
                hdr_kind = KIND_ANGLE;
            end
            else if (window_reg[7:0] == TYPE_PRESS_A && rx_byte == TYPE_PRESS_B)
            begin
                hdr_hit  = 1'b1;
                hdr_kind = KIND_PRESSURE;
            end
            else if (window_reg[7:0] == TYPE_ESTOP_A && rx_byte == TYPE_ESTOP_B)
            begin
                hdr_hit  = 1'b1;
                hdr_kind = KIND_ESTOP;
            end
            else if (window_reg[7:0] == TYPE_BRAKE_A && rx_byte == TYPE_BRAKE_B)
            begin
                hdr_hit  = 1'b1;
                hdr_kind = KIND_BRAKE;
            end
        end
    end

    // Payload length of the frame in progress
    always_comb
    begin
        unique case (kind_reg)
            KIND_ANGLE:    frame_len = LEN_CHAN;
            KIND_PRESSURE: frame_len = LEN_CHAN;
            KIND_ESTOP:    frame_len = LEN_ESTOP;
            KIND_BRAKE:    frame_len = LEN_BRAKE;
            default:       frame_len = LEN_CHAN;
        endcase
    end

    assign index_inc = {1'b0, index_reg} + LEN_W'(1);
    assign last_byte = in_frame_reg && (index_inc >= frame_len);

    // Payload as seen with the current beat merged in
    always_comb
    begin
        for (int k = 0; k < PAYLOAD_BYTES; k++)
        begin
            if (in_frame_reg && index_reg == IDX_W'(k))
                view[k] = rx_byte;
            else
                view[k] = payload_reg[k];
        end
    end

    assign done.valid = step && last_byte;
    assign done.kind  = kind_reg;
    assign done.bytes = view;

    // Next state of the hunter and frame counter
    always_comb
    begin
        window_next   = window_reg;
        in_frame_next = in_frame_reg;
        kind_next     = kind_reg;
        index_next    = index_reg;
        if (in_frame_reg)
        begin
            if (last_byte)
            begin
                in_frame_next = 1'b0;
                index_next    = '0;
            end
            else
            begin
                index_next = index_inc[IDX_W-1:0];
            end
        end
        else if (hdr_hit)
        begin
            in_frame_next = 1'b1;
            kind_next     = hdr_kind;
            index_next    = '0;
            window_next   = '0;
        end
        else
        begin
            window_next = {window_reg[15:0], rx_byte};
        end
        // end of buffer drops the window and any partial frame
        if (buffer_end)
        begin
            window_next   = '0;
            in_frame_next = 1'b0;
            index_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= '0;
            in_frame_reg <= 1'b0;
            kind_reg     <= KIND_ANGLE;
            index_reg    <= '0;
        end
        else if (step)
        begin
            window_reg   <= window_next;
            in_frame_reg <= in_frame_next;
            kind_reg     <= kind_next;
            index_reg    <= index_next;
        end
    end

    // Payload store, written at the byte counter
    always_ff @(posedge clk)
    begin
        if (step && in_frame_reg)
            payload_reg <= view;
    end

endmodule

`default_nettype wire

/* hw/rtl/sfd_spike.sv */
`default_nettype none

module sfd_spike
    import sfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire frame_done_t done,
    input  wire logic [15:0] spike_limit,
    output result_t          res
);

    logic [15:0]        last_reg [CHANNELS];
    logic [LANES-1:0]   take;
    logic [15:0]        raw    [LANES];
    logic [15:0]        kept   [LANES];
    logic               is_angle;

    assign is_angle = (done.kind == KIND_ANGLE);

    // Per-channel spike compare against the last accepted value
    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        if (g < CHANNELS)
        begin : g_real
            logic [16:0] diff;
            logic [16:0] mag;
            assign raw[g]  = {done.bytes[2*g+1], done.bytes[2*g]};
            assign diff    = {raw[g][15], raw[g]} - {last_reg[g][15], last_reg[g]};
            assign mag     = diff[16] ? (17'd0 - diff) : diff;
            assign take[g] = (mag < {1'b0, spike_limit});
            assign kept[g] = take[g] ? raw[g] : last_reg[g];
        end
        else
        begin : g_none
            assign raw[g]  = '0;
            assign take[g] = 1'b1;
            assign kept[g] = '0;
        end
    end

    // Result formatting
    always_comb
    begin
        res = '0;
        res.kind = done.kind;
        unique case (done.kind)
            KIND_ANGLE:
            begin
                for (int i = 0; i < OUT_CH; i++)
                begin
                    res.ch[i]   = kept[i];
                    res.held[i] = !take[i];
                end
            end
            KIND_PRESSURE:
            begin
                for (int i = 0; i < OUT_CH; i++)
                    res.ch[i] = raw[i];
            end
            KIND_ESTOP:
                res.estop = (done.bytes[0] != 8'd0);
            KIND_BRAKE:
            begin
                res.brake_a = done.bytes[0];
                res.brake_b = done.bytes[2];
            end
            default:
                res = '0;
        endcase
    end

    // Last accepted angles, updated once per angle frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
                last_reg[i] <= '0;
        end
        else if (done.valid && is_angle)
        begin
            for (int i = 0; i < CHANNELS; i++)
                last_reg[i] <= kept[i];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/suspension_feedback_deframer.sv */
// Suspension feedback deframer.
// A frame's completing beat passes the input register, then its result is loaded
// into the result register. Throughput: one byte beat per cycle while the result
// register is empty or being taken; the result register loads on each frame.
// Reset (rst_n low, asynchronous): hunting, empty window, angles zero,
// spike limit 1000; the payload store is not cleared.
`default_nettype none

module suspension_feedback_deframer
    import sfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    sfd_rx_if.sink           rx,
    sfd_frame_if.source      frame
);

    logic           s1_valid_reg;
    logic [7:0]     s1_byte_reg;
    logic           s1_end_reg;
    logic           step;
    logic [15:0]    spike_limit_reg;
    logic           out_valid_reg;
    result_t        out_reg;
    frame_done_t    done;
    result_t        res;

    // Byte advances when the result register has room
    assign step     = s1_valid_reg && (!out_valid_reg || frame.ready);
    assign rx.ready = !s1_valid_reg || step;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            spike_limit_reg <= SPIKE_LIMIT_RESET;
        else if (cfg_wr_en)
            spike_limit_reg <= cfg_wr_data;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (rx.ready)
            s1_valid_reg <= rx.valid;
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            s1_byte_reg <= rx.rx_byte;
            s1_end_reg  <= rx.buffer_end;
        end
    end

    sfd_framer u_framer (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .rx_byte    (s1_byte_reg),
        .buffer_end (s1_end_reg),
        .done       (done)
    );

    sfd_spike u_spike (
        .clk         (clk),
        .rst_n       (rst_n),
        .done        (done),
        .spike_limit (spike_limit_reg),
        .res         (res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (done.valid)
            out_valid_reg <= 1'b1;
        else if (frame.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done.valid)
            out_reg <= res;
    end

    assign frame.valid          = out_valid_reg;
    assign frame.frame_kind     = out_reg.kind;
    assign frame.ch0            = out_reg.ch[0];
    assign frame.ch1            = out_reg.ch[1];
    assign frame.ch2            = out_reg.ch[2];
    assign frame.ch3            = out_reg.ch[3];
    assign frame.ch4            = out_reg.ch[4];
    assign frame.ch5            = out_reg.ch[5];
    assign frame.held_mask      = out_reg.held;
    assign frame.emergency_stop = out_reg.estop;
    assign frame.brake_limit_a  = out_reg.brake_a;
    assign frame.brake_limit_b  = out_reg.brake_b;

endmodule

`default_nettype wire

/* hw/rtl/sfd_checker.sv */
`default_nettype none

module sfd_checker
    import sfd_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        rx_ready,
    input wire logic        frame_valid,
    input wire logic        frame_ready,
    input wire logic [1:0]  frame_kind,
    input wire logic [5:0]  held_mask,
    input wire logic        emergency_stop,
    input wire logic [7:0]  brake_limit_a,
    input wire logic [7:0]  brake_limit_b
);

    // Stalled result beat keeps its kind
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && !frame_ready |=> frame_valid && $stable(frame_kind))
        else $error("result beat changed while stalled");

    // Held flags only on angle frames
    a_held_angle: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_kind != KIND_ANGLE |-> held_mask == 6'd0)
        else $error("held flags on a non-angle frame");

    // Stop and brake fields only in their own frames
    a_side_fields: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid |-> (frame_kind == KIND_ESTOP || !emergency_stop)
            && (frame_kind == KIND_BRAKE
                || (brake_limit_a == 8'd0 && brake_limit_b == 8'd0)))
        else $error("field set outside its frame kind");

    // Input side never stalls while the result side is empty
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !frame_valid |-> rx_ready)
        else $error("input stalled with no result pending");

    // No result beat right after reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !frame_valid)
        else $error("result beat directly after reset");

endmodule

bind suspension_feedback_deframer sfd_checker u_sfd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rx_ready       (rx.ready),
    .frame_valid    (frame.valid),
    .frame_ready    (frame.ready),
    .frame_kind     (frame.frame_kind),
    .held_mask      (frame.held_mask),
    .emergency_stop (frame.emergency_stop),
    .brake_limit_a  (frame.brake_limit_a),
    .brake_limit_b  (frame.brake_limit_b)
);

`default_nettype wire
